// ===== rtl/core/sesd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesd_pkg
// Shared types and constants for the sound event stream decoder.
// ----------------------------------------------------------------------------
package sesd_pkg;

    localparam int  BYTE_W      = 8;
    localparam int  COUNT_W     = 2;
    localparam int  TDATA_IN_W  = 8;
    localparam int  TDATA_OUT_W = 40;

    // opcode classes and operand masks
    localparam logic [7:0] OP_FIRST_CMD = 8'hF8;
    localparam logic [7:0] OP_END_CMD   = 8'hFF;
    localparam logic [7:0] NOTE_LEN_BIT = 8'h80;
    localparam logic [7:0] NOTE_MASK    = 8'h7F;
    localparam logic [7:0] SUB_MASK     = 8'hE0;
    localparam logic [7:0] SUB_ONCE_A   = 8'h40;
    localparam logic [7:0] SUB_ONCE_B   = 8'h60;
    localparam logic [7:0] SUB_FINISH   = 8'hA0;

    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

    typedef struct packed {
        logic                is_cmd;
        logic [BYTE_W-1:0]   code;
        logic                has_len;
        logic [BYTE_W-1:0]   len;
        logic [COUNT_W-1:0]  count;
        logic [BYTE_W-1:0]   first;
        logic [BYTE_W-1:0]   second;
        logic                done;
    } event_t;

endpackage

// ===== rtl/core/sesd_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesd_decoder
// Parse state machine: consumes one byte per fire and forms at most one event.
// ----------------------------------------------------------------------------
module sesd_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [sesd_pkg::BYTE_W-1:0] byte_in,
    input  logic                        last_in,
    output logic                        ev_valid,
    output sesd_pkg::event_t            ev
);

    localparam logic [2:0] PH_OPCODE   = 3'd0;
    localparam logic [2:0] PH_OPERAND  = 3'd1;
    localparam logic [2:0] PH_SECOND   = 3'd2;
    localparam logic [2:0] PH_DURATION = 3'd3;
    localparam logic [2:0] PH_ENDED    = 3'd4;

    logic [2:0]                  phase_reg,   phase_next;
    logic [sesd_pkg::BYTE_W-1:0] opcode_reg,  opcode_next;
    logic [sesd_pkg::BYTE_W-1:0] operand_reg, operand_next;
    logic                        once_reg,    once_next;

    logic [sesd_pkg::BYTE_W-1:0] sub;
    logic                        ended;

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        operand_next = operand_reg;
        once_next    = once_reg;
        ev_valid     = 1'b0;
        ev           = '0;
        ended        = 1'b0;
        sub          = byte_in & sesd_pkg::SUB_MASK;

        case (phase_reg)
            PH_OPCODE:
            begin
                if (byte_in >= sesd_pkg::OP_FIRST_CMD)
                begin
                    opcode_next = byte_in;
                    phase_next  = PH_OPERAND;
                    // truncated command: operands zero-filled
                    ev_valid      = last_in;
                    ev.is_cmd     = 1'b1;
                    ev.code       = byte_in;
                    ev.count      = (byte_in == sesd_pkg::OP_END_CMD) ?
                                    sesd_pkg::CNT_TWO : sesd_pkg::CNT_ONE;
                    ev.done       = 1'b1;
                end
                else if ((byte_in & sesd_pkg::NOTE_LEN_BIT) != '0)
                begin
                    opcode_next = byte_in;
                    phase_next  = PH_DURATION;
                    ev_valid    = last_in;
                    ev.code     = byte_in & sesd_pkg::NOTE_MASK;
                    ev.has_len  = 1'b1;
                    ev.done     = 1'b1;
                end
                else
                begin
                    ev_valid = 1'b1;
                    ev.code  = byte_in;
                    ev.done  = last_in;
                end
            end
            PH_OPERAND:
            begin
                if (opcode_reg == sesd_pkg::OP_END_CMD)
                begin
                    operand_next  = byte_in;
                    phase_next    = PH_SECOND;
                    ev_valid      = last_in;
                    ev.is_cmd     = 1'b1;
                    ev.code       = sesd_pkg::OP_END_CMD;
                    ev.count      = sesd_pkg::CNT_TWO;
                    ev.first      = byte_in;
                    ev.done       = 1'b1;
                end
                else
                begin
                    phase_next = PH_OPCODE;
                    if (opcode_reg == sesd_pkg::OP_FIRST_CMD)
                    begin
                        if (sub inside {sesd_pkg::SUB_ONCE_A, sesd_pkg::SUB_ONCE_B})
                        begin
                            once_next = 1'b1;
                        end
                        else if (sub == sesd_pkg::SUB_FINISH && !once_reg)
                        begin
                            ended      = 1'b1;
                            phase_next = PH_ENDED;
                        end
                    end
                    ev_valid      = 1'b1;
                    ev.is_cmd     = 1'b1;
                    ev.code       = opcode_reg;
                    ev.count      = sesd_pkg::CNT_ONE;
                    ev.first      = byte_in;
                    ev.done       = ended || last_in;
                end
            end
            PH_SECOND:
            begin
                phase_next    = PH_ENDED;
                ev_valid      = 1'b1;
                ev.is_cmd     = 1'b1;
                ev.code       = sesd_pkg::OP_END_CMD;
                ev.count      = sesd_pkg::CNT_TWO;
                ev.first      = operand_reg;
                ev.second     = byte_in;
                ev.done       = 1'b1;
            end
            PH_DURATION:
            begin
                phase_next = PH_OPCODE;
                ev_valid   = 1'b1;
                ev.code    = opcode_reg & sesd_pkg::NOTE_MASK;
                ev.has_len = 1'b1;
                ev.len     = byte_in;
                ev.done    = last_in;
            end
            default:
            begin
                // stream ended: bytes are dropped
                ev_valid = 1'b0;
            end
        endcase

        if (last_in)
        begin
            phase_next   = PH_OPCODE;
            opcode_next  = '0;
            operand_next = '0;
            once_next    = 1'b0;
        end

        ev_valid = ev_valid && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OPCODE;
            opcode_reg  <= '0;
            operand_reg <= '0;
            once_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            operand_reg <= operand_next;
            once_reg    <= once_next;
        end
    end

endmodule

// ===== rtl/core/sound_event_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_event_stream_decoder
// Byte-wise decoder of a sound channel command stream into note and command
// events.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result side accepts events: a byte is
// registered on input, decoded by the parse state machine and the resulting
// event (if any) is registered on output. Output backpressure stalls the
// input register only when the result register is full and not being
// drained.
module sound_event_stream_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sesd_pkg::TDATA_IN_W-1:0]     s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // slice_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] event_code, [8] note_has_length, [16:9] note_length,
    // [18:17] operand_count, [26:19] operand_first, [34:27] operand_second,
    // [39:35] zero
    output logic [sesd_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                m_tuser,  // command flag, 1 command
    output logic                                m_tlast   // stream_done
);

    logic                        in_valid_reg;
    logic [sesd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;
    logic                        out_valid_reg, out_valid_next;
    sesd_pkg::event_t            out_ev_reg;

    logic                        out_free;
    logic                        fire;
    logic                        ev_valid;
    sesd_pkg::event_t            ev;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[sesd_pkg::BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    sesd_decoder u_decoder
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .byte_in  (in_byte_reg),
        .last_in  (in_last_reg),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ev_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_valid)
        begin
            out_ev_reg <= ev;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg.is_cmd;
    assign m_tlast  = out_ev_reg.done;
    assign m_tdata  = {5'd0, out_ev_reg.second, out_ev_reg.first, out_ev_reg.count,
                       out_ev_reg.len, out_ev_reg.has_len, out_ev_reg.code};

    // a parked word moves on whenever the result side can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_free) |=> (!in_valid_reg || $past(s_tvalid && s_tready)))
        else $error("input word not consumed");

    // note events never carry operands, commands always do
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == 1'b0) == (out_ev_reg.count == sesd_pkg::CNT_NONE)))
        else $error("operand count does not match event kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (out_ev_reg.code[7] == 1'b0))
        else $error("note value wider than 7 bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (out_ev_reg.code >= sesd_pkg::OP_FIRST_CMD))
        else $error("command event with non-command code");

endmodule

// ===== verif/sesd_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesd_event_checker
// Predicts the decoder's events from the input words and compares them with
// the events on the output stream.
// ----------------------------------------------------------------------------
// Every accepted input word runs through a byte-wise model of the decoder.
// A completed event is queued; every accepted output word is checked field
// by field against the oldest queued event. Mismatch count and queue depth
// go back to the testbench.
module sesd_event_checker
    import sesd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   m_tuser,
    input  logic                   m_tlast,
    output int                     errors,
    output int                     pending
);

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_OPERAND  = 3'd1,
        PH_SECOND   = 3'd2,
        PH_DURATION = 3'd3,
        PH_ENDED    = 3'd4
    } parse_phase_t;

    parse_phase_t phase;
    logic [7:0]   held_code;
    logic [7:0]   held_first;
    logic         once_open;

    event_t       expected_events[$];

    function automatic event_t command_event(input logic [7:0] code,
                                             input logic [COUNT_W-1:0] count,
                                             input logic [7:0] first,
                                             input logic [7:0] second,
                                             input logic done);
        event_t ev;
        ev            = '0;
        ev.is_cmd     = 1'b1;
        ev.code       = code;
        ev.count      = count;
        ev.first      = first;
        ev.second     = second;
        ev.done       = done;
        return ev;
    endfunction

    function automatic event_t note_event(input logic [7:0] value,
                                          input logic has_len,
                                          input logic [7:0] len,
                                          input logic done);
        event_t ev;
        ev         = '0;
        ev.code    = value & NOTE_MASK;
        ev.has_len = has_len;
        ev.len     = has_len ? len : 8'h00;
        ev.count   = CNT_NONE;
        ev.done    = done;
        return ev;
    endfunction

    task automatic clear_decoder();
        phase      = PH_OPCODE;
        held_code  = 8'h00;
        held_first = 8'h00;
        once_open  = 1'b0;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        clear_decoder();
    end

    // advance the decoder model by one byte, queue the event it completes
    task automatic decode_stream_byte(input logic [7:0] b, input logic last);
        event_t     ev;
        logic       got;
        logic       ends;
        logic [7:0] sub;
        got  = 1'b0;
        ends = 1'b0;
        ev   = '0;
        sub  = b & SUB_MASK;
        case (phase)
            PH_OPCODE:
            begin
                if (b >= OP_FIRST_CMD)
                begin
                    held_code = b;
                    phase     = PH_OPERAND;
                    if (last)
                    begin
                        ev  = command_event(b, (b == OP_END_CMD) ? CNT_TWO : CNT_ONE,
                                            8'h00, 8'h00, 1'b1);
                        got = 1'b1;
                    end
                end
                else if ((b & NOTE_LEN_BIT) != 8'h00)
                begin
                    held_code = b;
                    phase     = PH_DURATION;
                    if (last)
                    begin
                        ev  = note_event(b, 1'b1, 8'h00, 1'b1);
                        got = 1'b1;
                    end
                end
                else
                begin
                    ev  = note_event(b, 1'b0, 8'h00, last);
                    got = 1'b1;
                end
            end
            PH_OPERAND:
            begin
                if (held_code == OP_END_CMD)
                begin
                    held_first = b;
                    phase      = PH_SECOND;
                    if (last)
                    begin
                        ev  = command_event(OP_END_CMD, CNT_TWO, b, 8'h00, 1'b1);
                        got = 1'b1;
                    end
                end
                else
                begin
                    phase = PH_OPCODE;
                    if (held_code == OP_FIRST_CMD)
                    begin
                        if (sub == SUB_ONCE_A || sub == SUB_ONCE_B)
                            once_open = 1'b1;
                        else if (sub == SUB_FINISH && !once_open)
                        begin
                            ends  = 1'b1;
                            phase = PH_ENDED;
                        end
                    end
                    ev  = command_event(held_code, CNT_ONE, b, 8'h00, ends || last);
                    got = 1'b1;
                end
            end
            PH_SECOND:
            begin
                ev    = command_event(OP_END_CMD, CNT_TWO, held_first, b, 1'b1);
                got   = 1'b1;
                phase = PH_ENDED;
            end
            PH_DURATION:
            begin
                ev    = note_event(held_code, 1'b1, b, last);
                got   = 1'b1;
                phase = PH_OPCODE;
            end
            default:
            begin
                // stream has ended, byte is dropped
            end
        endcase
        if (got)
            expected_events = {expected_events, ev};
        if (last)
            clear_decoder();
    endtask

    task automatic report_field(input string field, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] event %s mismatch: expected %02h, got %02h",
                         $realtime, field, exp_val, act_val);
        end
    endtask

    task automatic check_event();
        event_t ev;
        if (expected_events.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] unexpected event word %010h user %b last %b",
                         $realtime, m_tdata, m_tuser, m_tlast);
        end
        else
        begin
            ev = expected_events.pop_front();
            report_field("cmd", {7'd0, ev.is_cmd}, {7'd0, m_tuser});
            report_field("code", ev.code, m_tdata[7:0]);
            report_field("has_len", {7'd0, ev.has_len}, {7'd0, m_tdata[8]});
            report_field("len", ev.len, m_tdata[16:9]);
            report_field("count", {6'd0, ev.count}, {6'd0, m_tdata[18:17]});
            report_field("first", ev.first, m_tdata[26:19]);
            report_field("second", ev.second, m_tdata[34:27]);
            report_field("pad", 8'h00, {3'd0, m_tdata[39:35]});
            report_field("done", {7'd0, ev.done}, {7'd0, m_tlast});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decoder();
            expected_events.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_event();
            if (s_tvalid && s_tready)
                decode_stream_byte(s_tdata[7:0], s_tlast);
        end
        pending = expected_events.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream stimulus and verdict for the sound event stream decoder.
// ----------------------------------------------------------------------------
// Sends a directed set of notes, commands, stream ends and slice truncations,
// then random slices built mostly from well-formed events with random
// operands, plus noise. Both stream sides idle at random; once the receiver
// holds off long enough to back the decoder up, and once the sender drains.
module tb_top;

    import sesd_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 28;

    // {slice_end, data_byte}
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        {1'b0, 8'h00}, {1'b0, 8'h7F}, {1'b0, 8'h80}, {1'b0, 8'hFF},
        {1'b0, 8'hF7}, {1'b0, 8'h00}, {1'b0, 8'hF9}, {1'b0, 8'hAA},
        {1'b0, 8'hFE}, {1'b0, 8'h55}, {1'b0, 8'hF8}, {1'b0, 8'h60},
        {1'b0, 8'hF8}, {1'b0, 8'hA0}, {1'b1, 8'h05}, {1'b0, 8'hF8},
        {1'b0, 8'hBF}, {1'b0, 8'h12}, {1'b1, 8'h34}, {1'b0, 8'hFF},
        {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b1, 8'h00}, {1'b1, 8'hFD},
        {1'b1, 8'h9A}, {1'b0, 8'hFF}, {1'b1, 8'h77}, {1'b1, 8'h7F}
    };

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int   errors;
    int   pending;
    int   sent_bytes  = 0;
    int   cycle_count = 0;

    logic hold_req    = 1'b0;
    bit   hold_served = 1'b0;
    int   stall_left  = 0;
    int   ready_left  = 0;
    bit   ready_on    = 1'b0;
    int   ready_pick;

    bit   sender_burst = 1'b0;
    bit   held_once    = 1'b0;
    bit   drained_once = 1'b0;
    logic [7:0] slice_bytes[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sound_event_stream_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sesd_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .errors     (errors),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random ready pattern, with one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                if (ready_left == 0)
                begin
                    ready_pick = $urandom_range(0, 99);
                    if (ready_pick < 10)
                    begin
                        ready_on   = 1'b1;
                        ready_left = $urandom_range(50, 150);
                    end
                    else if (ready_pick < 70)
                    begin
                        ready_on   = 1'b1;
                        ready_left = $urandom_range(1, 8);
                    end
                    else if (ready_pick < 95)
                    begin
                        ready_on   = 1'b0;
                        ready_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        ready_on   = 1'b0;
                        ready_left = $urandom_range(10, 40);
                    end
                end
                m_tready <= ready_on;
                ready_left--;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // called just after posedge clk; returns once the word has been taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sent_bytes++;
    endtask

    function automatic logic [7:0] play_control_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return SUB_FINISH | 8'($urandom_range(0, 31));
        else if (r < 45)
            return SUB_ONCE_A | 8'($urandom_range(0, 31));
        else if (r < 60)
            return SUB_ONCE_B | 8'($urandom_range(0, 31));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // one slice: mostly whole events with random content, some noise
    task automatic build_slice();
        int len;
        int r;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                           : $urandom_range(25, 120);
        slice_bytes.delete();
        while (slice_bytes.size() < len)
        begin
            r = $urandom_range(0, 99);
            if (r < 28)
                slice_bytes = {slice_bytes, 8'($urandom_range(0, 127))};
            else if (r < 48)
            begin
                slice_bytes = {slice_bytes, 8'($urandom_range(128, 247))};
                slice_bytes = {slice_bytes, 8'($urandom_range(0, 255))};
            end
            else if (r < 68)
            begin
                slice_bytes = {slice_bytes, 8'($urandom_range(249, 254))};
                slice_bytes = {slice_bytes, 8'($urandom_range(0, 255))};
            end
            else if (r < 86)
            begin
                slice_bytes = {slice_bytes, OP_FIRST_CMD};
                slice_bytes = {slice_bytes, play_control_operand()};
            end
            else if (r < 91)
            begin
                slice_bytes = {slice_bytes, OP_END_CMD};
                slice_bytes = {slice_bytes, 8'($urandom_range(0, 255))};
                slice_bytes = {slice_bytes, 8'($urandom_range(0, 255))};
            end
            else
                slice_bytes = {slice_bytes, 8'($urandom_range(0, 255))};
        end
        while (slice_bytes.size() > len)
            void'(slice_bytes.pop_back());
    endtask

    // sample the queue depth away from the active edge
    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        while (sent_bytes < ITEM_TARGET)
        begin
            build_slice();
            sender_burst = ($urandom_range(0, 3) == 0);
            if (!held_once && sent_bytes > 500)
            begin
                // sender keeps offering words through the receiver hold-off
                held_once    = 1'b1;
                sender_burst = 1'b1;
                hold_req    <= 1'b1;
            end
            if (!drained_once && sent_bytes > 1200)
            begin
                drained_once = 1'b1;
                s_tvalid    <= 1'b0;
                wait_drained();
                repeat (6) @(posedge clk);
            end
            for (int i = 0; i < slice_bytes.size(); i++)
                send_byte(slice_bytes[i], i == slice_bytes.size() - 1);
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
